### sv/gnms_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gnms_pkg - shared definitions for the gradient non-max suppression unit
// Field widths, register indexes, direction bin edges and the suppression
// decision used by the window stage.
// ----------------------------------------------------------------------------
package gnms_pkg;

    // Payload field widths
    localparam int MAG_W     = 8;
    localparam int ANG_W     = 9;
    localparam int OUT_COL_W = 10;
    localparam int OUT_ROW_W = 12;

    // Configuration register widths and limits
    localparam int CFG_W_W          = 11;
    localparam int CFG_H_W          = 13;
    localparam int CFG_DATA_W       = 13;
    localparam int CFG_ADDR_W       = 1;
    localparam int FRAME_MIN        = 3;
    localparam int FRAME_HEIGHT_MAX = 4096;
    localparam int FRAME_WIDTH_RST  = 640;
    localparam int FRAME_HEIGHT_RST = 480;
    localparam int MAX_WIDTH_DEF    = 1024;

    // Stream packing
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 32;

    // Register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] CFG_FRAME_HEIGHT = 1'b1;

    // Direction bin edges in half degrees (22.5, 67.5, 112.5, 157.5, 180 deg)
    localparam logic [ANG_W-1:0] ANG_BIN_1 = 9'd45;
    localparam logic [ANG_W-1:0] ANG_BIN_2 = 9'd135;
    localparam logic [ANG_W-1:0] ANG_BIN_3 = 9'd225;
    localparam logic [ANG_W-1:0] ANG_BIN_4 = 9'd315;
    localparam logic [ANG_W-1:0] ANG_MAX   = 9'd360;

    // 3x3 magnitude window, index = row * 3 + col, row 0 is the oldest line
    typedef logic [8:0][MAG_W-1:0] t_win;

    // Keep the centre only if it is not below either neighbor along the
    // gradient direction; an out-of-range angle compares against full scale.
    function automatic logic [MAG_W-1:0] nms_pick(t_win win, logic [ANG_W-1:0] ang);
        logic [MAG_W-1:0] a;
        logic [MAG_W-1:0] b;
        logic [MAG_W-1:0] c;
        c = win[4];
        if (ang < ANG_BIN_1 || (ang >= ANG_BIN_4 && ang <= ANG_MAX)) begin
            a = win[3];
            b = win[5];
        end else if (ang < ANG_BIN_2) begin
            a = win[2];
            b = win[6];
        end else if (ang < ANG_BIN_3) begin
            a = win[1];
            b = win[7];
        end else if (ang < ANG_BIN_4) begin
            a = win[0];
            b = win[8];
        end else begin
            a = '1;
            b = '1;
        end
        return (c < a || c < b) ? '0 : c;
    endfunction

endpackage

### sv/gnms_line_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gnms_line_ram - one line store
// Single write port, single read port, registered read data. A read and a
// write to the same address in one cycle return the old contents.
// ----------------------------------------------------------------------------
module gnms_line_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [DATA_W-1:0]        i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [DATA_W-1:0]        o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### sv/gradient_non_max_suppression_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gradient_non_max_suppression_unit - Canny non-maximum suppression
// Streams raster pixels (magnitude, direction) through line stores into a
// 3x3 window and thins edges along the gradient direction.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream: one pixel per request, tdata = {angle_half_deg, magnitude},
//   tuser = frame_start on the first pixel of a frame (optional; positions
//   also wrap at frame_width x frame_height).
//   Master stream: one result per interior pixel, tdata = {row, col, value},
//   tlast on the final interior pixel of the frame. Border pixels give none.
//   Config: i_cfg_we / i_cfg_addr / i_cfg_wdata, index 0 frame_width,
//   index 1 frame_height; write only while the unit is idle.
// Timing:
//   Throughput one pixel per clock while the receiver keeps tready high. An
//   accepted pixel is registered in the line-store read stage; when that
//   stage advances, the window and the result register load together, so a
//   result becomes valid as the read stage holding its lower-right neighbor
//   advances. The read stage and the result register form a two-deep pipe.
// Reset and stall:
//   Synchronous active-low reset empties the pipe, clears window and position
//   state and sets 640 x 480. Line stores are not cleared. When the receiver
//   holds tready low the result register holds, the read stage fills, and
//   tready on the slave side drops until the result is taken.
// ----------------------------------------------------------------------------
module gradient_non_max_suppression_unit
    import gnms_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Configuration write port
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    // Pixel stream in
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    input  logic [IN_DATA_W-1:0]  i_s_axis_tdata,   // [7:0] magnitude, [16:8] angle_half_deg
    input  logic                  i_s_axis_tuser,   // [0] frame_start
    // Result stream out
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    output logic [OUT_DATA_W-1:0] o_m_axis_tdata,   // [7:0] out_value, [17:8] out_col,
                                                    // [29:18] out_row
    output logic                  o_m_axis_tlast    // out_last
);

    localparam int CW      = $clog2(MAX_WIDTH);
    localparam int MW_BITS = $clog2(MAX_WIDTH + 1);
    localparam int EW      = (MW_BITS > CFG_W_W) ? MW_BITS : CFG_W_W;
    localparam int HW      = CFG_H_W;
    localparam int RST_W_I = (FRAME_WIDTH_RST > MAX_WIDTH) ? MAX_WIDTH : FRAME_WIDTH_RST;
    localparam logic [EW-1:0] W_MIN   = EW'(FRAME_MIN);
    localparam logic [EW-1:0] W_MAX   = EW'(MAX_WIDTH);
    localparam logic [EW-1:0] W_RST   = EW'(RST_W_I);
    localparam logic [HW-1:0] H_MIN   = HW'(FRAME_MIN);
    localparam logic [HW-1:0] H_MAX   = HW'(FRAME_HEIGHT_MAX);
    localparam logic [HW-1:0] H_RST   = HW'(FRAME_HEIGHT_RST);

    // ------------------------------------------------------------------
    // Effective (saturated) frame size
    // ------------------------------------------------------------------
    logic [EW-1:0] r_eff_w;
    logic [HW-1:0] r_eff_h;
    logic [EW-1:0] cfg_w;
    logic [HW-1:0] cfg_h;

    assign cfg_w = EW'(i_cfg_wdata[CFG_W_W-1:0]);
    assign cfg_h = i_cfg_wdata[CFG_H_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eff_w <= W_RST;
            r_eff_h <= H_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_FRAME_WIDTH: begin
                    r_eff_w <= (cfg_w < W_MIN) ? W_MIN : (cfg_w > W_MAX) ? W_MAX : cfg_w;
                end
                CFG_FRAME_HEIGHT: begin
                    r_eff_h <= (cfg_h < H_MIN) ? H_MIN : (cfg_h > H_MAX) ? H_MAX : cfg_h;
                end
                default: begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Handshake and pipe control
    // ------------------------------------------------------------------
    logic r_s1_vld;
    logic r_out_vld;
    logic s_acc;
    logic s1_adv;

    assign s1_adv          = r_s1_vld && (!r_out_vld || i_m_axis_tready);
    assign o_s_axis_tready = !r_s1_vld || s1_adv;
    assign s_acc           = i_s_axis_tvalid && o_s_axis_tready;

    // ------------------------------------------------------------------
    // Position of the arriving pixel
    // ------------------------------------------------------------------
    logic [CW-1:0]        r_col;
    logic [OUT_ROW_W-1:0] r_row;
    logic [CW-1:0]        cur_col;
    logic [OUT_ROW_W-1:0] cur_row;
    logic [EW-1:0]        cur_col_x;
    logic [HW-1:0]        cur_row_x;
    logic                 cur_emit;
    logic                 cur_last;
    logic                 col_wrap;
    logic                 row_wrap;
    logic [MAG_W-1:0]     in_mag;
    logic [ANG_W-1:0]     in_ang;

    assign in_mag    = i_s_axis_tdata[MAG_W-1:0];
    assign in_ang    = i_s_axis_tdata[MAG_W+ANG_W-1:MAG_W];
    assign cur_col   = i_s_axis_tuser ? '0 : r_col;
    assign cur_row   = i_s_axis_tuser ? '0 : r_row;
    assign cur_col_x = EW'(cur_col);
    assign cur_row_x = HW'(cur_row);
    assign col_wrap  = cur_col_x >= (r_eff_w - 1'b1);
    assign row_wrap  = cur_row_x >= (r_eff_h - 1'b1);
    assign cur_emit  = (cur_col_x >= EW'(2)) && (cur_row_x >= HW'(2))
                    && (cur_col_x < r_eff_w) && (cur_row_x < r_eff_h);
    assign cur_last  = (cur_col_x == r_eff_w - 1'b1) && (cur_row_x == r_eff_h - 1'b1);

    // Step the raster position on each accepted pixel
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (s_acc) begin
            if (col_wrap) begin
                r_col <= '0;
                r_row <= row_wrap ? '0 : cur_row + 1'b1;
            end else begin
                r_col <= cur_col + 1'b1;
                r_row <= cur_row;
            end
        end
    end

    // ------------------------------------------------------------------
    // Read stage: line-store reads issued on accept
    // ------------------------------------------------------------------
    logic [CW-1:0]        r_s1_addr;
    logic [OUT_ROW_W-1:0] r_s1_row;
    logic                 r_s1_emit;
    logic                 r_s1_last;
    logic [MAG_W-1:0]     r_s1_mag;
    logic                 r_byp_hit;
    logic [MAG_W-1:0]     r_byp_data;
    logic [MAG_W-1:0]     top_rd;
    logic [MAG_W-1:0]     mid_rd;
    logic [ANG_W-1:0]     ang_rd;
    logic [MAG_W-1:0]     top_val;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_byp_hit <= 1'b0;
        end else if (s_acc) begin
            r_s1_vld  <= 1'b1;
            // Top line write of the previous pixel lands this same edge
            r_byp_hit <= s1_adv && (cur_col == r_s1_addr);
        end else if (s1_adv) begin
            r_s1_vld  <= 1'b0;
            r_byp_hit <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_s1_addr  <= cur_col;
            r_s1_row   <= cur_row;
            r_s1_emit  <= cur_emit;
            r_s1_last  <= cur_last;
            r_s1_mag   <= in_mag;
            r_byp_data <= mid_rd;
        end
    end

    // Middle line: takes the new magnitude on accept
    gnms_line_ram #(
        .DATA_W (MAG_W),
        .DEPTH  (MAX_WIDTH)
    ) u_mid_line (
        .i_clk   (i_clk),
        .i_we    (s_acc),
        .i_waddr (cur_col),
        .i_wdata (in_mag),
        .i_re    (s_acc),
        .i_raddr (cur_col),
        .o_rdata (mid_rd)
    );

    // Top line: takes the old middle-line entry once it has been read
    gnms_line_ram #(
        .DATA_W (MAG_W),
        .DEPTH  (MAX_WIDTH)
    ) u_top_line (
        .i_clk   (i_clk),
        .i_we    (s1_adv),
        .i_waddr (r_s1_addr),
        .i_wdata (mid_rd),
        .i_re    (s_acc),
        .i_raddr (cur_col),
        .o_rdata (top_rd)
    );

    // Direction line
    gnms_line_ram #(
        .DATA_W (ANG_W),
        .DEPTH  (MAX_WIDTH)
    ) u_ang_line (
        .i_clk   (i_clk),
        .i_we    (s_acc),
        .i_waddr (cur_col),
        .i_wdata (in_ang),
        .i_re    (s_acc),
        .i_raddr (cur_col),
        .o_rdata (ang_rd)
    );

    assign top_val = r_byp_hit ? r_byp_data : top_rd;

    // ------------------------------------------------------------------
    // Window stage: shift in a column and decide the centre
    // ------------------------------------------------------------------
    t_win             r_win;
    t_win             n_win;
    logic [ANG_W-1:0] r_cang0;

    always_comb begin
        n_win    = r_win;
        n_win[0] = r_win[1];
        n_win[1] = r_win[2];
        n_win[2] = top_val;
        n_win[3] = r_win[4];
        n_win[4] = r_win[5];
        n_win[5] = mid_rd;
        n_win[6] = r_win[7];
        n_win[7] = r_win[8];
        n_win[8] = r_s1_mag;
    end

    // The centre's direction is the one held before this column shifts in
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win   <= '0;
            r_cang0 <= '0;
        end else if (s1_adv) begin
            r_win   <= n_win;
            r_cang0 <= ang_rd;
        end
    end

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    logic [MAG_W-1:0]     r_out_value;
    logic [OUT_COL_W-1:0] r_out_col;
    logic [OUT_ROW_W-1:0] r_out_row;
    logic                 r_out_last;
    logic [CW-1:0]        s1_col_m1;

    assign s1_col_m1 = r_s1_addr - 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (s1_adv) begin
            r_out_vld <= r_s1_emit;
        end else if (i_m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out_value <= nms_pick(n_win, r_cang0);
            r_out_col   <= OUT_COL_W'(s1_col_m1);
            r_out_row   <= r_s1_row - 1'b1;
            r_out_last  <= r_s1_last;
        end
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = {(OUT_DATA_W - MAG_W - OUT_COL_W - OUT_ROW_W)'(0),
                              r_out_row, r_out_col, r_out_value};
    assign o_m_axis_tlast  = r_out_last;

`ifndef SYNTHESIS
    // Slave side only stalls while the read stage is occupied
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> r_s1_vld)
        else $error("input stalled with empty read stage");

    // The frame's last pixel always lies inside the frame
    a_last_is_emitted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_vld && r_s1_last) |-> r_s1_emit)
        else $error("last marker on a border pixel");

    // Top-line bypass is only set while the read stage holds a pixel
    a_bypass_with_pixel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_byp_hit |-> r_s1_vld)
        else $error("top-line bypass with an empty read stage");

    // A new result only comes from an advancing read stage
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_vld) |-> $past(s1_adv && r_s1_emit))
        else $error("result appeared without a source pixel");
`endif

endmodule

### dv/gradient_non_max_suppression_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gradient_non_max_suppression_unit_tb - self-checking bench for the NMS unit
// Streams raster frames of (magnitude, direction) pixels through the unit,
// predicts every interior result in a scoreboard with its own line stores and
// window, and compares each result field by field. Both streams idle and
// stall at random; frame sizes change between phases, including saturated
// settings, wrap-around, restarts and mid-row width cuts.
// ----------------------------------------------------------------------------
module gradient_non_max_suppression_unit_tb;
    import gnms_pkg::*;

    localparam int MAX_W         = MAX_WIDTH_DEF;
    localparam int PIPE_SETTLE   = 6;     // settling wait for the two-deep pipe to empty
    localparam int PIXEL_BUDGET  = 700;   // pixels sent over the whole run
    localparam int SAT_RUN_LEN   = 150;   // pixels sent under each saturated size
    localparam int DIRECTED_LEN  = 24;

    // Direction bins along which the center is compared
    typedef enum logic [2:0] {
        DIR_HORZ,
        DIR_RISING,
        DIR_VERT,
        DIR_FALLING,
        DIR_INVALID
    } t_dir_bin;

    typedef struct {
        logic [MAG_W-1:0]     value;
        logic [OUT_COL_W-1:0] col;
        logic [OUT_ROW_W-1:0] row;
        logic                 last;
    } t_nms_result;

    // Scoreboard: tracks the unit's state and holds the thinned pixels due
    class nms_scoreboard;
        logic [CFG_W_W-1:0] width_reg;
        logic [CFG_H_W-1:0] height_reg;
        logic [MAG_W-1:0]   line_top [MAX_W];   // two rows up
        logic [MAG_W-1:0]   line_mid [MAX_W];   // one row up
        logic [ANG_W-1:0]   line_ang [MAX_W];
        logic [MAG_W-1:0]   win [9];            // row * 3 + col, row 0 oldest
        logic [ANG_W-1:0]   ang_next;           // direction heading for the center
        logic [ANG_W-1:0]   ang_center;
        int unsigned        col_q;
        int unsigned        row_q;
        t_nms_result        thinned_pixels [$];
        int unsigned        mismatches = 0;
        int unsigned        results_seen = 0;

        function void reset_state();
            width_reg  = FRAME_WIDTH_RST;
            height_reg = FRAME_HEIGHT_RST;
            foreach (line_top[i]) begin
                line_top[i] = '0;
                line_mid[i] = '0;
                line_ang[i] = '0;
            end
            foreach (win[i]) win[i] = '0;
            ang_next   = '0;
            ang_center = '0;
            col_q      = 0;
            row_q      = 0;
            thinned_pixels.delete();
        endfunction

        function void write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_FRAME_WIDTH:  width_reg  = val[CFG_W_W-1:0];
                CFG_FRAME_HEIGHT: height_reg = val[CFG_H_W-1:0];
                default: ;
            endcase
        endfunction

        function int unsigned eff_width();
            if (width_reg < FRAME_MIN) return FRAME_MIN;
            if (width_reg > MAX_W) return MAX_W;
            return width_reg;
        endfunction

        function int unsigned eff_height();
            if (height_reg < FRAME_MIN) return FRAME_MIN;
            if (height_reg > FRAME_HEIGHT_MAX) return FRAME_HEIGHT_MAX;
            return height_reg;
        endfunction

        function t_dir_bin bin_of(logic [ANG_W-1:0] ang);
            if (ang > ANG_MAX) return DIR_INVALID;
            if (ang < ANG_BIN_1 || ang >= ANG_BIN_4) return DIR_HORZ;
            if (ang < ANG_BIN_2) return DIR_RISING;
            if (ang < ANG_BIN_3) return DIR_VERT;
            return DIR_FALLING;
        endfunction

        // Center survives only if no neighbor along the direction is larger
        function logic [MAG_W-1:0] thin_center(logic [ANG_W-1:0] ang);
            logic [MAG_W-1:0] n0;
            logic [MAG_W-1:0] n1;
            case (bin_of(ang))
                DIR_HORZ:    begin n0 = win[3]; n1 = win[5]; end
                DIR_RISING:  begin n0 = win[2]; n1 = win[6]; end
                DIR_VERT:    begin n0 = win[1]; n1 = win[7]; end
                DIR_FALLING: begin n0 = win[0]; n1 = win[8]; end
                default:     begin n0 = '1;     n1 = '1;     end
            endcase
            return (win[4] >= n0 && win[4] >= n1) ? win[4] : '0;
        endfunction

        // Accepted pixel request: update stores and window, queue any result
        function void note_pixel(logic [MAG_W-1:0] mag, logic [ANG_W-1:0] ang,
                                 logic frame_start);
            int unsigned      w;
            int unsigned      h;
            int unsigned      c;
            int unsigned      r;
            int unsigned      idx;
            logic [MAG_W-1:0] up2;
            logic [MAG_W-1:0] up1;
            t_nms_result      res;
            w = eff_width();
            h = eff_height();
            if (frame_start) begin
                col_q = 0;
                row_q = 0;
            end
            c   = col_q;
            r   = row_q;
            idx = (c < MAX_W) ? c : MAX_W - 1;

            up2 = line_top[idx];
            up1 = line_mid[idx];
            line_top[idx] = up1;
            line_mid[idx] = mag;
            ang_center    = ang_next;
            ang_next      = line_ang[idx];
            line_ang[idx] = ang;

            // shift the window left, new column enters on the right
            for (int k = 0; k < 9; k += 3) begin
                win[k]   = win[k+1];
                win[k+1] = win[k+2];
            end
            win[2] = up2;
            win[5] = up1;
            win[8] = mag;

            if (c >= 2 && r >= 2 && c < w && r < h) begin
                res.value = thin_center(ang_center);
                res.col   = OUT_COL_W'(c - 1);
                res.row   = OUT_ROW_W'(r - 1);
                res.last  = (c == w - 1 && r == h - 1);
                thinned_pixels.push_back(res);
            end

            if (c + 1 >= w) begin
                col_q = 0;
                row_q = (r + 1 >= h) ? 0 : r + 1;
            end else begin
                col_q = c + 1;
            end
        endfunction

        function void compare_field(string name, int unsigned expv, int unsigned act);
            if (expv != act) begin
                mismatches++;
                $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, expv, act);
            end
        endfunction

        // Accepted result request: compare with the oldest pending pixel
        function void check_result(logic [OUT_DATA_W-1:0] data, logic last);
            t_nms_result exp_px;
            results_seen++;
            if (thinned_pixels.size() == 0) begin
                mismatches++;
                $display("%0t: result with none pending, expected nothing actual %h last %0b",
                         $time, data, last);
                return;
            end
            exp_px = thinned_pixels.pop_front();
            compare_field("out_value", exp_px.value, data[MAG_W-1:0]);
            compare_field("out_col", exp_px.col, data[MAG_W +: OUT_COL_W]);
            compare_field("out_row", exp_px.row, data[MAG_W+OUT_COL_W +: OUT_ROW_W]);
            compare_field("out_last", exp_px.last, last);
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0] i_cfg_addr = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;
    logic                  i_s_axis_tvalid = 1'b0;
    logic                  o_s_axis_tready;
    logic [IN_DATA_W-1:0]  i_s_axis_tdata = '0;
    logic                  i_s_axis_tuser = 1'b0;
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] o_m_axis_tdata;
    logic                  o_m_axis_tlast;

    nms_scoreboard sb;
    logic          idle_on = 1'b0;
    int unsigned   ready_hold = 0;
    int unsigned   pixels_sent = 0;
    int unsigned   size_writes = 0;

    gradient_non_max_suppression_unit u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    always #5 i_clk = ~i_clk;

    // Mostly short gaps, a few long ones; none while idling is off
    function automatic int unsigned pick_gap();
        int unsigned pick;
        if (!idle_on) return 0;
        pick = $urandom_range(0, 99);
        if (pick < 60) return 0;
        if (pick < 94) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [MAG_W-1:0] rand_mag();
        int unsigned pick;
        pick = $urandom_range(0, 19);
        if (pick == 0) return '0;
        if (pick == 1) return '1;
        return MAG_W'($urandom_range(0, (1 << MAG_W) - 1));
    endfunction

    // Mostly legal directions, some on bin boundaries, some above 180 degrees
    function automatic logic [ANG_W-1:0] rand_angle();
        int unsigned pick;
        int unsigned bound;
        pick = $urandom_range(0, 99);
        if (pick < 70) return ANG_W'($urandom_range(0, ANG_MAX));
        if (pick < 88) begin
            case ($urandom_range(0, 4))
                0:       bound = ANG_BIN_1;
                1:       bound = ANG_BIN_2;
                2:       bound = ANG_BIN_3;
                3:       bound = ANG_BIN_4;
                default: bound = ANG_MAX + 1;
            endcase
            return ANG_W'(bound - $urandom_range(0, 1));
        end
        return ANG_W'($urandom_range(ANG_MAX + 1, (1 << ANG_W) - 1));
    endfunction

    // Mostly in range, sometimes below the minimum or beyond the usual size
    function automatic int unsigned pick_size(int unsigned hi, int unsigned far);
        case ($urandom_range(0, 9))
            0:       return $urandom_range(0, FRAME_MIN - 1);
            1:       return $urandom_range(hi + 1, far);
            default: return $urandom_range(FRAME_MIN, hi);
        endcase
    endfunction

    // Result side: random stalls, monitor checks every accepted result
    always @(posedge i_clk) begin
        if (!idle_on) begin
            i_m_axis_tready <= 1'b1;
            ready_hold = 0;
        end else if (ready_hold != 0) begin
            ready_hold--;
        end else if (i_m_axis_tready) begin
            ready_hold = pick_gap();
            if (ready_hold != 0) begin
                i_m_axis_tready <= 1'b0;
                ready_hold--;
            end else begin
                ready_hold = $urandom_range(0, 6);
            end
        end else begin
            i_m_axis_tready <= 1'b1;
            ready_hold = $urandom_range(0, 6);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            sb.check_result(o_m_axis_tdata, o_m_axis_tlast);
        end
    end

    // Write the width register, then the height register; the unit must be idle
    task automatic set_frame_size(int unsigned w, int unsigned h);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= CFG_FRAME_WIDTH;
        i_cfg_wdata <= CFG_DATA_W'(w);
        @(posedge i_clk);
        sb.write_reg(CFG_FRAME_WIDTH, CFG_DATA_W'(w));
        i_cfg_addr  <= CFG_FRAME_HEIGHT;
        i_cfg_wdata <= CFG_DATA_W'(h);
        @(posedge i_clk);
        sb.write_reg(CFG_FRAME_HEIGHT, CFG_DATA_W'(h));
        i_cfg_we    <= 1'b0;
        size_writes++;
    endtask

    task automatic send_pixel(logic [MAG_W-1:0] mag, logic [ANG_W-1:0] ang,
                              logic frame_start);
        int unsigned gap;
        gap = pick_gap();
        if (gap != 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= IN_DATA_W'({ang, mag});
        i_s_axis_tuser  <= frame_start;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        sb.note_pixel(mag, ang, frame_start);
        pixels_sent++;
    endtask

    // Random pixels; stops early once the pixel budget is spent
    task automatic send_run(int unsigned count, logic with_start);
        for (int unsigned i = 0; i < count; i++) begin
            if (pixels_sent >= PIXEL_BUDGET) break;
            send_pixel(rand_mag(), rand_angle(), with_start && i == 0);
        end
    endtask

    // Stop sending, wait for every pending result, then let the pipe settle
    task automatic drain_results();
        i_s_axis_tvalid <= 1'b0;
        while (sb.thinned_pixels.size() != 0) @(posedge i_clk);
        repeat (PIPE_SETTLE) @(posedge i_clk);
    endtask

    initial begin
        // 8x3 frame: row 1 centers cover every direction bin and a bad angle
        logic [MAG_W-1:0] dir_mag [DIRECTED_LEN] = '{
            10, 255,   0,  40, 200,  90,   0, 255,
            20, 200, 255, 128, 255,   7, 255,  60,
            30, 100,  30, 128,   0,   8, 255, 254};
        logic [ANG_W-1:0] dir_ang [DIRECTED_LEN] = '{
            45, 134, 135, 224, 225, 314, 315,  44,
           100,   0,  90, 180, 270, 360, 511, 300,
           256, 511,   0, 361,  12, 200, 170,  80};
        int unsigned w_reg;
        int unsigned h_reg;
        int unsigned ew;
        int unsigned eh;
        int unsigned npx;
        int unsigned stop_col;
        int unsigned stop_row;
        int unsigned cut_w;
        int unsigned phase;

        sb = new();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        sb.reset_state();

        // directed frame, smallest height
        set_frame_size(8, FRAME_MIN);
        for (int i = 0; i < DIRECTED_LEN; i++) begin
            send_pixel(dir_mag[i], dir_ang[i], i == 0);
        end
        drain_results();

        phase = 0;
        while (pixels_sent < PIXEL_BUDGET) begin
            phase++;
            if (phase <= 2) begin
                // saturated width, then saturated height, back to back
                idle_on = 1'b0;
                if (phase == 1) set_frame_size(2047, 0);
                else set_frame_size(0, 8191);
                send_run(SAT_RUN_LEN, 1'b1);
            end else begin
                w_reg   = pick_size(12, 40);
                h_reg   = pick_size(8, 20);
                idle_on = ($urandom_range(0, 3) != 0);
                set_frame_size(w_reg, h_reg);
                ew  = sb.eff_width();
                eh  = sb.eff_height();
                npx = ew * eh;
                case ($urandom_range(0, 9)) inside
                    // second frame starts by wrap-around, no frame start flag
                    [0:1]: begin
                        send_run(npx, 1'b1);
                        send_run(npx, 1'b0);
                    end
                    // frame cut short by a new frame start
                    [2:3]: begin
                        send_run($urandom_range(1, npx - 1), 1'b1);
                        send_run(npx, 1'b1);
                    end
                    // width cut mid-row: next pixel lands past the new width
                    [4:5]: begin
                        if (ew >= 4) begin
                            stop_col = $urandom_range(FRAME_MIN, ew - 1);
                            stop_row = $urandom_range(0, eh - 1);
                            send_run(stop_row * ew + stop_col, 1'b1);
                            drain_results();
                            cut_w = $urandom_range(FRAME_MIN, stop_col);
                            set_frame_size(cut_w, h_reg);
                            send_run(cut_w * eh * 2, 1'b0);
                        end else begin
                            send_run(npx, 1'b1);
                        end
                    end
                    default: send_run(npx, 1'b1);
                endcase
            end
            drain_results();
        end

        $display("Streamed %0d pixels, checked %0d results over %0d frame-size writes.",
                 pixels_sent, sb.results_seen, size_writes);
        $display("Frames up to 40x20 plus saturated width and height, with wraps, restarts, cuts.");
        if (sb.mismatches == 0 && sb.thinned_pixels.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run
    initial begin
        #(64'd10_000_000);
        $display("Timeout with %0d results still pending.", sb.thinned_pixels.size());
        $display("CHECK FAILED");
        $finish;
    end

endmodule
